@@ hdl/svm_pkg.sv @@
// Shared constants, types and arithmetic helpers for the sample voice mixer.
package svm_pkg;

    localparam int VOICES       = 8;
    localparam int SAMPLE_BYTES = 65536;
    localparam int VOICE_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SADDR_W      = $clog2(SAMPLE_BYTES);
    localparam int MASK_W       = 8;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic signed [15:0] MIX_MAX = 16'sd32767;
    localparam logic signed [15:0] MIX_MIN = -16'sd32768;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] length;
        logic [31:0] pos;
        logic [18:0] step;
        logic [14:0] gain_l;
        logic [14:0] gain_r;
        logic        play;
        logic        loop;
        logic        wide;
        logic        dual;
    } t_voice;

    // Add a Q1.14 product (truncated toward zero) to a running sum, then clamp.
    function automatic logic signed [15:0] mix_add(input logic signed [15:0] acc,
                                                   input logic signed [31:0] prod);
        logic signed [31:0] adj;
        logic signed [17:0] q;
        logic signed [18:0] s;
        adj = prod + (prod[31] ? 32'sd16383 : 32'sd0);
        q   = 18'(adj >>> 14);
        s   = 19'(acc) + 19'(q);
        if (s > 19'(MIX_MAX)) begin
            return MIX_MAX;
        end else if (s < 19'(MIX_MIN)) begin
            return MIX_MIN;
        end
        return 16'(s);
    endfunction

endpackage

@@ hdl/sample_voice_mixer_top.sv @@
// Sample voice mixer: sample store, voice table and per-tick mixing sequencer.
//
// Input channel (i_valid / o_stall) carries one item: write a sample byte,
// start a voice, or tick. Byte writes and voice starts complete without leaving the idle state.
// A tick walks the voice table in index order and returns one stereo frame
// plus the ended mask on the output channel (o_valid / i_stall).
// Per voice: S_VRD and S_VCHK read the voice entry, then a playing voice
// reads the sample store in S_RD1 (8-bit) or S_RD1 and S_RD2 (16-bit)
// and goes through the shared multiplier and write-back in S_ML, S_MR
// and S_WB. The steps are serialised by the single read port of each
// memory and the one multiplier.
// The block is busy (o_stall high) while a tick runs; one finished frame
// waits in the output register while the next item is taken. If a second
// frame completes while the first is still stalled, the sequencer holds.
// Reset clears the voice table valid bits (all voices silent), the done
// flags and the output valid flag; sample store contents are undefined until
// written and must be written before a voice plays them.
module sample_voice_mixer_top
    import svm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_voice,
    input  logic [15:0]        i_address,
    input  logic [7:0]         i_data_byte,
    input  logic [15:0]        i_frame_count,
    input  logic [18:0]        i_step_rate,
    input  logic [14:0]        i_gain_left,
    input  logic [14:0]        i_gain_right,
    input  logic               i_repeat_req,
    input  logic               i_wide_format,
    input  logic               i_two_channel_source,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_mix_left,
    output logic signed [15:0] o_mix_right,
    output logic [7:0]         o_ended_mask
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_VRD  = 4'd1;
    localparam logic [3:0] S_VCHK = 4'd2;
    localparam logic [3:0] S_RD1  = 4'd3;
    localparam logic [3:0] S_RD2  = 4'd4;
    localparam logic [3:0] S_ML   = 4'd5;
    localparam logic [3:0] S_MR   = 4'd6;
    localparam logic [3:0] S_WB   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic [VOICE_W-1:0] LAST_V = VOICE_W'(VOICES - 1);

    logic [7:0]         smem [SAMPLE_BYTES];
    t_voice             vmem [VOICES];

    logic [3:0]         r_state, n_state;
    logic [VOICE_W-1:0] r_v, n_v;
    logic [VOICES-1:0]  r_vld, n_vld;
    logic [MASK_W-1:0]  r_done, n_done;
    logic               r_vq_vld;
    t_voice             r_vq;
    t_voice             r_ent, n_ent;
    logic [7:0]         r_sdata;
    logic [7:0]         r_hi, n_hi;
    logic [SADDR_W-1:0] r_saddr, n_saddr;
    logic signed [15:0] r_samp, n_samp;
    logic signed [31:0] r_prod, n_prod;
    logic signed [15:0] r_acc_l, n_acc_l;
    logic signed [15:0] r_acc_r, n_acc_r;
    logic               r_oval, n_oval;
    logic signed [15:0] r_out_l, n_out_l;
    logic signed [15:0] r_out_r, n_out_r;
    logic [MASK_W-1:0]  r_out_m, n_out_m;

    logic               accept;
    logic               s_we;
    logic [SADDR_W-1:0] s_raddr;
    logic               v_we;
    logic [VOICE_W-1:0] v_waddr;
    t_voice             v_wdata;
    t_voice             cur;
    t_voice             st;
    logic [15:0]        frame;
    logic [31:0]        addr32;
    logic [32:0]        pos_sum;

    assign o_stall      = (r_state != S_IDLE);
    assign accept       = i_valid && (r_state == S_IDLE);
    assign s_we         = accept && (i_op == OP_WRITE);
    assign o_valid      = r_oval;
    assign o_mix_left   = r_out_l;
    assign o_mix_right  = r_out_r;
    assign o_ended_mask = r_out_m;

    assign cur = r_vq_vld ? r_vq : '0;

    always_comb begin
        st        = '0;
        st.base   = i_address;
        st.length = i_frame_count;
        st.step   = i_step_rate;
        st.gain_l = i_gain_left;
        st.gain_r = i_gain_right;
        st.play   = 1'b1;
        st.loop   = i_repeat_req;
        st.wide   = i_wide_format;
        st.dual   = i_two_channel_source;
    end

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_vld   = r_vld;
        n_done  = r_done;
        n_ent   = r_ent;
        n_hi    = r_hi;
        n_saddr = r_saddr;
        n_samp  = r_samp;
        n_prod  = r_prod;
        n_acc_l = r_acc_l;
        n_acc_r = r_acc_r;
        n_oval  = r_oval && i_stall;
        n_out_l = r_out_l;
        n_out_r = r_out_r;
        n_out_m = r_out_m;
        v_we    = 1'b0;
        v_waddr = r_v;
        v_wdata = cur;
        s_raddr = r_saddr;
        frame   = cur.pos[31:16];
        addr32  = '0;
        pos_sum = 33'(r_ent.pos) + 33'(r_ent.step);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_TICK: begin
                            n_v     = '0;
                            n_acc_l = '0;
                            n_acc_r = '0;
                            n_state = S_VRD;
                        end
                        OP_START: begin
                            if (32'(i_voice) < VOICES) begin
                                v_we    = 1'b1;
                                v_waddr = VOICE_W'(i_voice);
                                v_wdata = st;
                                n_vld   = r_vld | (VOICES'(1) << VOICE_W'(i_voice));
                                n_done  = r_done & ~(MASK_W'(1) << i_voice);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_VRD: begin
                n_state = S_VCHK;
            end
            S_VCHK: begin
                n_ent = cur;
                if (!cur.play) begin
                    n_state = (r_v == LAST_V) ? S_FIN : S_VRD;
                    n_v     = r_v + 1'b1;
                end else if (frame >= cur.length && !cur.loop) begin
                    v_we         = 1'b1;
                    v_wdata.play = 1'b0;
                    n_done       = r_done | MASK_W'(MASK_W'(1) << r_v);
                    n_state      = (r_v == LAST_V) ? S_FIN : S_VRD;
                    n_v          = r_v + 1'b1;
                end else begin
                    if (frame >= cur.length) begin
                        // wrap a looping voice back to its first frame
                        n_ent.pos = '0;
                        frame     = '0;
                    end
                    addr32  = 32'(cur.base) + (32'(frame) << (32'(cur.wide) + 32'(cur.dual)));
                    s_raddr = addr32[SADDR_W-1:0];
                    n_saddr = s_raddr;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                if (r_ent.wide) begin
                    n_hi    = r_sdata;
                    s_raddr = r_saddr + 1'b1;
                    n_state = S_RD2;
                end else begin
                    n_samp  = {r_sdata ^ 8'h80, 8'h00};
                    n_state = S_ML;
                end
            end
            S_RD2: begin
                n_samp  = {r_hi, r_sdata};
                n_state = S_ML;
            end
            S_ML: begin
                n_prod  = r_samp * $signed({1'b0, r_ent.gain_l});
                n_state = S_MR;
            end
            S_MR: begin
                n_acc_l = mix_add(r_acc_l, r_prod);
                n_prod  = r_samp * $signed({1'b0, r_ent.gain_r});
                n_state = S_WB;
            end
            S_WB: begin
                n_acc_r     = mix_add(r_acc_r, r_prod);
                v_we        = 1'b1;
                v_wdata     = r_ent;
                // saturate on carry so the voice ends (or wraps, if looping) on its next visit
                v_wdata.pos = pos_sum[32] ? '1 : pos_sum[31:0];
                n_state     = (r_v == LAST_V) ? S_FIN : S_VRD;
                n_v         = r_v + 1'b1;
            end
            S_FIN: begin
                if (!r_oval || !i_stall) begin
                    n_oval  = 1'b1;
                    n_out_l = r_acc_l;
                    n_out_r = r_acc_r;
                    n_out_m = r_done;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            smem[i_address[SADDR_W-1:0]] <= i_data_byte;
        end
        r_sdata <= smem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            vmem[v_waddr] <= v_wdata;
        end
        r_vq     <= vmem[r_v];
        r_vq_vld <= r_vld[r_v];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v     <= '0;
            r_vld   <= '0;
            r_done  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v     <= n_v;
            r_vld   <= n_vld;
            r_done  <= n_done;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_hi    <= n_hi;
        r_saddr <= n_saddr;
        r_samp  <= n_samp;
        r_prod  <= n_prod;
        r_acc_l <= n_acc_l;
        r_acc_r <= n_acc_r;
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
        r_out_m <= n_out_m;
    end

    a_chk_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_VCHK |-> $past(r_state) == S_VRD)
        else $error("voice check without a preceding entry read");

    a_frame_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_FIN)
        else $error("frame presented outside the finish step");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall)
        else $error("input taken while a tick is running");

    a_wide_second_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD2 |-> $past(r_state) == S_RD1 && r_ent.wide)
        else $error("second sample byte read for a narrow voice");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the sample voice mixer top level.
module tb
    import svm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_GAP    = 12;
    localparam int IDLE_LIMIT = 4000;
    localparam int RAND_ITEMS = 750;

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  voice;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [15:0] frame_count;
        logic [18:0] step_rate;
        logic [14:0] gain_left;
        logic [14:0] gain_right;
        logic        repeat_req;
        logic        wide_format;
        logic        two_channel;
        logic        drain;
    } t_mix_item;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [7:0]         ended;
    } t_mix_frame;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_op = '0;
    logic [2:0]         i_voice = '0;
    logic [15:0]        i_address = '0;
    logic [7:0]         i_data_byte = '0;
    logic [15:0]        i_frame_count = '0;
    logic [18:0]        i_step_rate = '0;
    logic [14:0]        i_gain_left = '0;
    logic [14:0]        i_gain_right = '0;
    logic               i_repeat_req = 1'b0;
    logic               i_wide_format = 1'b0;
    logic               i_two_channel_source = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_mix_left;
    logic signed [15:0] o_mix_right;
    logic [7:0]         o_ended_mask;

    sample_voice_mixer_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus bookkeeping
    t_mix_item  pending_items[$];
    t_mix_frame expected_frames[$];
    bit         byte_written[SAMPLE_BYTES];
    int         error_count;
    int         frames_checked;
    int         ticks_sent;
    int         starts_sent;
    int         idle_cycles;
    bit         burst_mode;

    // Shadow of the mixer state
    logic [7:0]  shadow_store[SAMPLE_BYTES];
    t_voice      shadow_voice[VOICES];
    logic [7:0]  shadow_ended;

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic int voice_sample(int v, logic [31:0] frame);
        logic [31:0] stride;
        logic [15:0] addr;
        logic [15:0] raw;
        stride = (shadow_voice[v].wide ? 2 : 1) * (shadow_voice[v].dual ? 2 : 1);
        addr   = 16'(32'(shadow_voice[v].base) + frame * stride);
        if (shadow_voice[v].wide) begin
            raw = {shadow_store[addr], shadow_store[16'(addr + 16'd1)]};
            return int'($signed(raw));
        end
        return (int'(shadow_store[addr]) - 128) * 256;
    endfunction

    function automatic int clamp_mix(int x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    // Apply one accepted item to the shadow state; queue the frame of a tick.
    function automatic void mixer_apply(t_mix_item it);
        int          acc_l;
        int          acc_r;
        int          s;
        logic [31:0] frame;
        t_mix_frame  fr;
        acc_l = 0;
        acc_r = 0;
        case (it.op)
            OP_WRITE: shadow_store[it.address] = it.data_byte;
            OP_START: begin
                shadow_voice[it.voice] = '{base: it.address, length: it.frame_count,
                    pos: '0, step: it.step_rate, gain_l: it.gain_left,
                    gain_r: it.gain_right, play: 1'b1, loop: it.repeat_req,
                    wide: it.wide_format, dual: it.two_channel};
                shadow_ended[it.voice] = 1'b0;
            end
            OP_TICK: begin
                for (int v = 0; v < VOICES; v++) begin
                    if (!shadow_voice[v].play) continue;
                    frame = shadow_voice[v].pos >> 16;
                    if (frame >= 32'(shadow_voice[v].length)) begin
                        if (shadow_voice[v].loop) begin
                            shadow_voice[v].pos = '0;
                            frame = '0;
                        end else begin
                            shadow_voice[v].play = 1'b0;
                            shadow_ended[v] = 1'b1;
                            continue;
                        end
                    end
                    s = voice_sample(v, frame);
                    acc_l = clamp_mix(acc_l + (s * int'(shadow_voice[v].gain_l)) / 16384);
                    acc_r = clamp_mix(acc_r + (s * int'(shadow_voice[v].gain_r)) / 16384);
                    if (shadow_voice[v].pos > 32'hFFFF_FFFF - 32'(shadow_voice[v].step))
                        shadow_voice[v].pos = 32'hFFFF_FFFF;
                    else
                        shadow_voice[v].pos += 32'(shadow_voice[v].step);
                end
                fr.left  = 16'(acc_l);
                fr.right = 16'(acc_r);
                fr.ended = shadow_ended;
                expected_frames.push_back(fr);
            end
            default: ;
        endcase
    endfunction

    function automatic t_mix_item blank_item(logic [1:0] op);
        t_mix_item it;
        it.op          = op;
        it.voice       = 3'($urandom);
        it.address     = 16'($urandom);
        it.data_byte   = 8'($urandom);
        it.frame_count = 16'($urandom);
        it.step_rate   = 19'($urandom);
        it.gain_left   = 15'($urandom);
        it.gain_right  = 15'($urandom);
        it.repeat_req  = 1'($urandom);
        it.wide_format = 1'($urandom);
        it.two_channel = 1'($urandom);
        it.drain       = 1'b0;
        return it;
    endfunction

    function automatic void queue_write(logic [15:0] addr, logic [7:0] data);
        t_mix_item it;
        it = blank_item(OP_WRITE);
        it.address   = addr;
        it.data_byte = data;
        byte_written[addr] = 1'b1;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_tick();
        pending_items.push_back(blank_item(OP_TICK));
    endfunction

    // Fill every byte the voice can ever read before it starts.
    function automatic void queue_start(logic [2:0] v, logic [15:0] base, logic [15:0] len,
                                        logic [18:0] step, logic [14:0] gl, logic [14:0] gr,
                                        logic lp, logic wide, logic dual);
        t_mix_item   it;
        int          frames;
        int          stride;
        logic [15:0] a;
        stride = (wide ? 2 : 1) * (dual ? 2 : 1);
        frames = (len == 0) ? (lp ? 1 : 0) : ((step == 0) ? 1 : int'(len));
        for (int f = 0; f < frames; f++) begin
            for (int b = 0; b < (wide ? 2 : 1); b++) begin
                a = 16'(int'(base) + f * stride + b);
                if (!byte_written[a]) queue_write(a, 8'($urandom));
            end
        end
        it = blank_item(OP_START);
        it.voice = v; it.address = base; it.frame_count = len; it.step_rate = step;
        it.gain_left = gl; it.gain_right = gr;
        it.repeat_req = lp; it.wide_format = wide; it.two_channel = dual;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_random_start();
        logic [15:0] base;
        logic [15:0] len;
        logic [18:0] step;
        int          sel;
        sel  = $urandom_range(0, 9);
        base = (sel == 0) ? 16'($urandom_range(65500, 65535)) :
               (sel == 1) ? 16'($urandom) : 16'($urandom_range(0, 511));
        sel  = $urandom_range(0, 9);
        len  = (sel == 0) ? 16'd0 : 16'($urandom_range(1, 24));
        sel  = $urandom_range(0, 9);
        step = (sel == 0) ? 19'd0 :
               (sel < 3) ? 19'($urandom_range(0, 524287)) : 19'($urandom_range(0, 32'h2FFFF));
        if ($urandom_range(0, 19) == 0) begin
            // long voice pinned to its first frame
            len  = 16'($urandom_range(1000, 65535));
            step = '0;
        end
        queue_start(3'($urandom), base, len, step, 15'($urandom), 15'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // Driver: present items from the pending queue with random gaps.
    int        gap_left;
    t_mix_item cur_item;

    always @(posedge i_clk) begin
        logic holding;
        logic next_valid;
        if (i_rst_n) begin
            holding    = i_valid;
            next_valid = i_valid;
            if (i_valid && !o_stall) begin
                mixer_apply(cur_item);
                if (cur_item.op == OP_TICK) ticks_sent++;
                if (cur_item.op == OP_START) starts_sent++;
                holding    = 1'b0;
                next_valid = 1'b0;
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && expected_frames.size() > 0)) begin
                    cur_item = pending_items.pop_front();
                    i_op          <= cur_item.op;
                    i_voice       <= cur_item.voice;
                    i_address     <= cur_item.address;
                    i_data_byte   <= cur_item.data_byte;
                    i_frame_count <= cur_item.frame_count;
                    i_step_rate   <= cur_item.step_rate;
                    i_gain_left   <= cur_item.gain_left;
                    i_gain_right  <= cur_item.gain_right;
                    i_repeat_req  <= cur_item.repeat_req;
                    i_wide_format <= cur_item.wide_format;
                    i_two_channel_source <= cur_item.two_channel;
                    next_valid = 1'b1;
                    if ($urandom_range(0, 63) == 0) burst_mode = !burst_mode;
                    gap_left = draw_gap();
                end
            end
            i_valid <= next_valid;
        end
    end

    // Monitor: stall the output at random and check each frame.
    int stall_left;

    always @(posedge i_clk) begin
        t_mix_frame want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                frames_checked++;
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected frame L=%0d R=%0d ended=%02h", $realtime,
                             o_mix_left, o_mix_right, o_ended_mask);
                    error_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (o_mix_left !== want.left) begin
                        $display("%0t: mix_left expected %0d actual %0d", $realtime,
                                 want.left, o_mix_left);
                        error_count++;
                    end
                    if (o_mix_right !== want.right) begin
                        $display("%0t: mix_right expected %0d actual %0d", $realtime,
                                 want.right, o_mix_right);
                        error_count++;
                    end
                    if (o_ended_mask !== want.ended) begin
                        $display("%0t: ended_mask expected %02h actual %02h", $realtime,
                                 want.ended, o_ended_mask);
                        error_count++;
                    end
                end
                stall_left = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            end
            i_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no progress", $realtime);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_mix_item it;
        int        sel;
        int        base_count;
        shadow_ended = '0;
        for (int v = 0; v < VOICES; v++) shadow_voice[v] = '0;
        for (int a = 0; a < SAMPLE_BYTES; a++) shadow_store[a] = '0;

        // Directed: extreme bytes, saturation, loop and end corner cases
        queue_write(16'd0, 8'd0);
        queue_write(16'd1, 8'd255);
        queue_write(16'd2, 8'd128);
        queue_write(16'd3, 8'd127);
        queue_write(16'hFFFF, 8'h80);
        queue_tick();
        queue_start(3'd7, 16'd0, 16'd2, 19'h10000, 15'h7FFF, 15'h7FFF, 1'b0, 1'b0, 1'b0);
        queue_start(3'd0, 16'd0, 16'd1, 19'h10000, 15'h7FFF, 15'd0, 1'b1, 1'b0, 1'b0);
        queue_start(3'd1, 16'hFFFF, 16'd0, 19'h7FFFF, 15'd16384, 15'h7FFF, 1'b1, 1'b1, 1'b0);
        queue_start(3'd2, 16'd2, 16'd0, 19'd0, 15'd16384, 15'd16384, 1'b0, 1'b0, 1'b1);
        queue_start(3'd3, 16'd1, 16'hFFFF, 19'd0, 15'd16384, 15'd100, 1'b0, 1'b1, 1'b1);
        it = blank_item(2'd3);
        pending_items.push_back(it);
        repeat (4) queue_tick();

        // Random: mostly voice starts and ticks over a pool of written bytes
        base_count = pending_items.size();
        while (pending_items.size() < base_count + RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                queue_tick();
            end else if (sel < 70) begin
                queue_random_start();
            end else if (sel < 92) begin
                queue_write(16'($urandom), 8'($urandom));
            end else begin
                it = blank_item(2'd3);
                pending_items.push_back(it);
            end
            if ($urandom_range(0, 99) == 0) pending_items[$].drain = 1'b1;
        end
        pending_items[pending_items.size() / 2].drain = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_frames.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Sent %0d ticks and %0d voice starts; checked %0d mixed frames.",
                 ticks_sent, starts_sent, frames_checked);
        if (error_count == 0 && expected_frames.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/svm_pkg.sv
hdl/sample_voice_mixer_top.sv
dv/tb.sv
